[src/gnr_pkg.sv]
package gnr_pkg;

  localparam int SRC_W = 11;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_GATE  = 2'd1;
  localparam logic [1:0] KIND_WIRE  = 2'd2;
  localparam logic [1:0] KIND_EVAL  = 2'd3;

  localparam logic [2:0] GT_AND  = 3'd0;
  localparam logic [2:0] GT_OR   = 3'd1;
  localparam logic [2:0] GT_NOT  = 3'd2;
  localparam logic [2:0] GT_XOR  = 3'd3;
  localparam logic [2:0] GT_NAND = 3'd4;
  localparam logic [2:0] GT_NOR  = 3'd5;
  localparam logic [2:0] GT_XNOR = 3'd6;

  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_GATE  = 2'd1;

  localparam logic       TO_PIN = 1'b0;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_CLR  = 11'b000_0000_0010,
    ST_ORD  = 11'b000_0000_0100,
    ST_PIN  = 11'b000_0000_1000,
    ST_SRC  = 11'b000_0001_0000,
    ST_OWN  = 11'b000_0010_0000,
    ST_UPD  = 11'b000_0100_0000,
    ST_OSRC = 11'b000_1000_0000,
    ST_OUPD = 11'b001_0000_0000,
    ST_END  = 11'b010_0000_0000,
    ST_RES  = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic clr_net;
    logic add_gate;
    logic add_wire;
    logic eval_start;
    logic clr_step;
    logic clr_pins;
    logic own_rd;
    logic out_rd;
    logic src_eval;
    logic gate_upd;
    logic bit_upd;
    logic sweep_end;
    logic next_sweep;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic gate_last;
    logic no_gates;
    logic bit_last;
    logic changed;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

[src/gnr_in_if.sv]
interface gnr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] gate_id;
  logic [2:0] gate_type;
  logic [1:0] src_kind;
  logic [7:0] from_id;
  logic       to_type;
  logic [7:0] to_id;
  logic [7:0] to_pin;
  logic [3:0] circuit_inputs;

  modport source (output valid, kind, gate_id, gate_type, src_kind, from_id, to_type,
                  to_id, to_pin, circuit_inputs, input ready);
  modport sink (input valid, kind, gate_id, gate_type, src_kind, from_id, to_type,
                to_id, to_pin, circuit_inputs, output ready);
endinterface

[src/gnr_out_if.sv]
interface gnr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] hex_value;
  logic       converged;

  modport source (output valid, hex_value, converged, input ready);
  modport sink (input valid, hex_value, converged, output ready);
endinterface

[src/gnr_ctrl.sv]
module gnr_ctrl import gnr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   pins_q, pins_d;
  logic   acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    pins_d  = pins_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (in_kind_i)
            KIND_CLEAR: begin
              cmd_o.clr_net = 1'b1;
              pins_d        = 1'b1;
              state_d       = ST_CLR;
            end
            KIND_GATE: cmd_o.add_gate = 1'b1;
            KIND_WIRE: cmd_o.add_wire = 1'b1;
            KIND_EVAL: begin
              cmd_o.eval_start = 1'b1;
              pins_d           = 1'b0;
              state_d          = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        cmd_o.clr_pins = pins_q;
        if (sts_i.clr_last) begin
          if (pins_q) begin
            state_d = ST_IDLE;
          end else if (sts_i.no_gates) begin
            state_d = ST_OSRC;
          end else begin
            state_d = ST_ORD;
          end
        end
      end
      ST_ORD: state_d = ST_PIN;
      ST_PIN: state_d = ST_SRC;
      ST_SRC: state_d = ST_OWN;
      ST_OWN: begin
        cmd_o.own_rd   = 1'b1;
        cmd_o.src_eval = 1'b1;
        state_d        = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.gate_upd = 1'b1;
        state_d        = sts_i.gate_last ? ST_OSRC : ST_ORD;
      end
      ST_OSRC: begin
        cmd_o.out_rd = 1'b1;
        state_d      = ST_OUPD;
      end
      ST_OUPD: begin
        cmd_o.bit_upd = 1'b1;
        state_d       = sts_i.bit_last ? ST_END : ST_OSRC;
      end
      ST_END: begin
        cmd_o.sweep_end = 1'b1;
        if (!sts_i.changed || sts_i.sweep_last) begin
          state_d = ST_RES;
        end else begin
          cmd_o.next_sweep = 1'b1;
          state_d          = sts_i.no_gates ? ST_OSRC : ST_ORD;
        end
      end
      ST_RES: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      pins_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      pins_q  <= pins_d;
    end
  end

endmodule

[src/gnr_datapath.sv]
module gnr_datapath import gnr_pkg::*; #(
  parameter int MAX_GATES    = 64,
  parameter int ID_SPACE     = 256,
  parameter int NUM_OUTS     = 4,
  parameter int EXTRA_SWEEPS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] gate_id_i,
  input  logic [2:0] gate_type_i,
  input  logic [1:0] src_kind_i,
  input  logic [7:0] from_id_i,
  input  logic       to_type_i,
  input  logic [7:0] to_id_i,
  input  logic [7:0] to_pin_i,
  input  logic [3:0] circuit_inputs_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] hex_value_o,
  output logic       converged_o
);

  localparam int IDW = $clog2(ID_SPACE);
  localparam int GIW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
  localparam int TW  = $clog2(MAX_GATES + 1);
  localparam int SW  = $clog2(MAX_GATES + EXTRA_SWEEPS + 1);
  localparam int OBW = (NUM_OUTS > 1) ? $clog2(NUM_OUTS) : 1;

  function automatic logic src_val(input logic [SRC_W-1:0] s, input logic [3:0] ib,
                                   input logic gv);
    logic [1:0] k;
    logic [7:0] id;
    k  = s[9:8];
    id = s[7:0];
    if (!s[10]) begin
      return 1'b0;
    end else if (k == SRC_INPUT) begin
      return (id < 8'd4) ? ib[id[1:0]] : 1'b0;
    end else if (k == SRC_GATE) begin
      return ({1'b0, id} < 9'(ID_SPACE)) ? gv : 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic logic gate_fn(input logic [2:0] t, input logic a, input logic b);
    case (t)
      GT_AND:  return a & b;
      GT_OR:   return a | b;
      GT_NOT:  return ~a;
      GT_XOR:  return a ^ b;
      GT_NAND: return ~(a & b);
      GT_NOR:  return ~(a | b);
      GT_XNOR: return ~(a ^ b);
      default: return 1'b0;
    endcase
  endfunction

  logic [2:0]       kind_mem [ID_SPACE];
  logic [IDW-1:0]   order_mem [MAX_GATES];
  logic [SRC_W-1:0] pin0_mem [ID_SPACE];
  logic [SRC_W-1:0] pin1_mem [ID_SPACE];
  logic             val_mem [ID_SPACE];
  logic [SRC_W-1:0] outsrc_q [NUM_OUTS];

  logic [TW-1:0]       total_q;
  logic [IDW-1:0]      clr_cnt_q;
  logic [GIW-1:0]      g_q;
  logic [SW-1:0]       sweep_q;
  logic [OBW-1:0]      bit_q;
  logic                changed_q, settled_q;
  logic [NUM_OUTS-1:0] latch_q;
  logic [3:0]          inbits_q;
  logic [IDW-1:0]      order_rd_q;
  logic [2:0]          kind_q;
  logic [SRC_W-1:0]    pin0_q, pin1_q;
  logic                va_q, vb_q, nv_q;
  logic                out_valid_q, conv_q;
  logic [3:0]          hex_q;

  logic                gid_ok, tid_ok, add_ok;
  logic [SRC_W-1:0]    wire_src;
  logic                pin0_we, pin1_we;
  logic [IDW-1:0]      pin_wa, val_wa, rda;
  logic [SRC_W-1:0]    pin_wd;
  logic                val_we, val_wd;
  logic                a_v, b_v, nvb;
  logic [SRC_W-1:0]    cur_out;
  logic [3:0]          hex_w;

  assign gid_ok   = ({1'b0, gate_id_i} < 9'(ID_SPACE));
  assign tid_ok   = ({1'b0, to_id_i} < 9'(ID_SPACE));
  assign add_ok   = cmd_i.add_gate && gid_ok && (total_q < TW'(MAX_GATES));
  assign wire_src = {1'b1, src_kind_i, from_id_i};
  assign cur_out  = outsrc_q[bit_q];

  always_comb begin
    pin0_we = cmd_i.clr_pins;
    pin1_we = cmd_i.clr_pins;
    pin_wa  = clr_cnt_q;
    pin_wd  = '0;
    if (cmd_i.add_wire && (to_type_i == TO_PIN) && tid_ok && (to_pin_i < 8'd2)) begin
      pin0_we = (to_pin_i == 8'd0);
      pin1_we = (to_pin_i == 8'd1);
      pin_wa  = to_id_i[IDW-1:0];
      pin_wd  = wire_src;
    end
  end

  assign val_we = cmd_i.clr_step || cmd_i.gate_upd;
  assign val_wa = cmd_i.clr_step ? clr_cnt_q : order_rd_q;
  assign val_wd = cmd_i.clr_step ? 1'b0 : nv_q;
  assign rda    = cmd_i.own_rd ? order_rd_q :
                  cmd_i.out_rd ? cur_out[IDW-1:0] : pin0_q[IDW-1:0];

  assign a_v = src_val(pin0_q, inbits_q, va_q);
  assign b_v = (kind_q == GT_NOT) ? 1'b0 : src_val(pin1_q, inbits_q, vb_q);
  assign nvb = src_val(cur_out, inbits_q, va_q);

  always_ff @(posedge clk_i) begin
    if (add_ok) begin
      kind_mem[gate_id_i[IDW-1:0]] <= gate_type_i;
      order_mem[total_q[GIW-1:0]]  <= gate_id_i[IDW-1:0];
    end
    if (pin0_we) pin0_mem[pin_wa] <= pin_wd;
    if (pin1_we) pin1_mem[pin_wa] <= pin_wd;
    if (val_we)  val_mem[val_wa]  <= val_wd;
    order_rd_q <= order_mem[g_q];
    kind_q     <= kind_mem[order_rd_q];
    pin0_q     <= pin0_mem[order_rd_q];
    pin1_q     <= pin1_mem[order_rd_q];
    va_q       <= val_mem[rda];
    vb_q       <= val_mem[pin1_q[IDW-1:0]];
    if (cmd_i.src_eval) nv_q <= gate_fn(kind_q, a_v, b_v);
    if (cmd_i.eval_start) inbits_q <= circuit_inputs_i;
    if (cmd_i.emit) begin
      hex_q  <= hex_w;
      conv_q <= settled_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_OUTS; i++) outsrc_q[i] <= '0;
      total_q     <= '0;
      clr_cnt_q   <= '0;
      g_q         <= '0;
      sweep_q     <= '0;
      bit_q       <= '0;
      changed_q   <= 1'b0;
      settled_q   <= 1'b0;
      latch_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_net) begin
        total_q <= '0;
        for (int i = 0; i < NUM_OUTS; i++) outsrc_q[i] <= '0;
      end
      if (add_ok) total_q <= total_q + TW'(1);
      if (cmd_i.add_wire && (to_type_i != TO_PIN) && (to_id_i == 8'd0) &&
          (to_pin_i < 8'(NUM_OUTS))) begin
        outsrc_q[to_pin_i[OBW-1:0]] <= wire_src;
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= sts_o.clr_last ? '0 : clr_cnt_q + IDW'(1);
      end
      if (cmd_i.eval_start) begin
        latch_q   <= '0;
        sweep_q   <= '0;
        g_q       <= '0;
        bit_q     <= '0;
        changed_q <= 1'b0;
      end
      if (cmd_i.gate_upd) begin
        g_q <= sts_o.gate_last ? '0 : g_q + GIW'(1);
        if (va_q != nv_q) changed_q <= 1'b1;
      end
      if (cmd_i.bit_upd) begin
        bit_q <= sts_o.bit_last ? '0 : bit_q + OBW'(1);
        if (nvb != latch_q[bit_q]) begin
          latch_q[bit_q] <= nvb;
          changed_q      <= 1'b1;
        end
      end
      if (cmd_i.sweep_end) settled_q <= !changed_q;
      if (cmd_i.next_sweep) begin
        sweep_q   <= sweep_q + SW'(1);
        changed_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_cnt_q == IDW'(ID_SPACE - 1));
  assign sts_o.gate_last  = ((TW'(g_q) + TW'(1)) == total_q);
  assign sts_o.no_gates   = (total_q == '0);
  assign sts_o.bit_last   = (bit_q == OBW'(NUM_OUTS - 1));
  assign sts_o.changed    = changed_q;
  assign sts_o.sweep_last = (sweep_q == (SW'(total_q) + SW'(EXTRA_SWEEPS - 1)));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  for (genvar i = 0; i < 4; i++) begin : g_hex
    if (i < NUM_OUTS) begin : g_on
      assign hex_w[i] = latch_q[i];
    end else begin : g_off
      assign hex_w[i] = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hex_value_o = hex_q;
  assign converged_o = conv_q;

endmodule

[src/gate_netlist_relaxation_sim_top.sv]
// Load items (clear excepted) leave the block idle; a new item is taken every cycle while no clear or evaluation runs.
// Clear netlist: busy while the pin table is swept.
// Evaluate: the value table is cleared, then each sweep evaluates every gate in order
//   and latches each output, for up to gates+EXTRA_SWEEPS sweeps, then the result is sent.
// Reset: asynchronous; a pin table clear runs before any transfer.
module gate_netlist_relaxation_sim_top import gnr_pkg::*; #(
  parameter int MAX_GATES    = 64,
  parameter int ID_SPACE     = 256,
  parameter int NUM_OUTS     = 4,
  parameter int EXTRA_SWEEPS = 10
) (
  input logic         clk_i,
  input logic         rst_ni,
  gnr_in_if.sink      in_i,
  gnr_out_if.source   out_o
);

  cmd_t cmd;
  sts_t sts;

  gnr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gnr_datapath #(
    .MAX_GATES    (MAX_GATES),
    .ID_SPACE     (ID_SPACE),
    .NUM_OUTS     (NUM_OUTS),
    .EXTRA_SWEEPS (EXTRA_SWEEPS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .gate_id_i        (in_i.gate_id),
    .gate_type_i      (in_i.gate_type),
    .src_kind_i       (in_i.src_kind),
    .from_id_i        (in_i.from_id),
    .to_type_i        (in_i.to_type),
    .to_id_i          (in_i.to_id),
    .to_pin_i         (in_i.to_pin),
    .circuit_inputs_i (in_i.circuit_inputs),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .hex_value_o      (out_o.hex_value),
    .converged_o      (out_o.converged)
  );

endmodule

[test/tb_gate_netlist_relaxation_sim_top.sv]
module tb_gate_netlist_relaxation_sim_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gnr_pkg::*;

  localparam int NGATE = 64;
  localparam int NID   = 256;
  localparam int NOUT  = 4;
  localparam int NXTRA = 10;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] gate_id;
    logic [2:0] gate_type;
    logic [1:0] src_kind;
    logic [7:0] from_id;
    logic       to_type;
    logic [7:0] to_id;
    logic [7:0] to_pin;
    logic [3:0] circuit_inputs;
    bit         typed;
    logic [3:0] hex;
    logic       conv;
  } item_t;

  typedef struct {
    logic [3:0] hex;
    logic       conv;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  gnr_in_if  in_if ();
  gnr_out_if out_if ();

  gate_netlist_relaxation_sim_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // netlist mirror
  logic [2:0]  kind_m [NID];
  logic [7:0]  order_m [NGATE];
  int          total_m;
  bit          val_m [NID];
  logic [10:0] pin_m [2*NID];
  logic [10:0] osrc_m [NOUT];
  logic [3:0]  latch_m;

  outcome_t    outcome_q [$];
  item_t       stim_q [$];
  item_t       dir_tab [23];
  bit          cur_typed;
  logic [3:0]  cur_hex;
  logic        cur_conv;
  int          n_err;
  int          n_eval;
  int          n_osc;
  int          n_big;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  function automatic bit src_val(logic [10:0] s, logic [3:0] cin);
    if (!s[10]) return 1'b0;
    if (s[9:8] == SRC_INPUT) return (s[7:0] < 4) ? cin[s[1:0]] : 1'b0;
    if (s[9:8] == SRC_GATE) return val_m[s[7:0]];
    return 1'b0;
  endfunction

  function automatic bit gate_fn(logic [2:0] t, bit a, bit b);
    case (t)
      GT_AND:  return a & b;
      GT_OR:   return a | b;
      GT_NOT:  return ~a;
      GT_XOR:  return a ^ b;
      GT_NAND: return ~(a & b);
      GT_NOR:  return ~(a | b);
      GT_XNOR: return ~(a ^ b);
      default: return 1'b0;
    endcase
  endfunction

  task automatic netlist_step(input item_t it, output bit has, output outcome_t res);
    int    lim;
    int    sw;
    bit    settled;
    bit    chg;
    bit    a;
    bit    b;
    bit    nv;
    int    id;
    has = 1'b0;
    res = '{hex: 4'd0, conv: 1'b0};
    case (it.kind)
      KIND_CLEAR: begin
        total_m = 0;
        foreach (pin_m[i]) pin_m[i] = '0;
        foreach (osrc_m[i]) osrc_m[i] = '0;
      end
      KIND_GATE: begin
        if (total_m < NGATE) begin
          kind_m[it.gate_id] = it.gate_type;
          order_m[total_m] = it.gate_id;
          total_m++;
        end
      end
      KIND_WIRE: begin
        if (it.to_type == TO_PIN) begin
          if (it.to_pin < 2) pin_m[it.to_id*2 + it.to_pin] = {1'b1, it.src_kind, it.from_id};
        end else if (it.to_id == 0 && it.to_pin < NOUT) begin
          osrc_m[it.to_pin[1:0]] = {1'b1, it.src_kind, it.from_id};
        end
      end
      default: begin
        lim = total_m + NXTRA;
        settled = 1'b0;
        foreach (val_m[i]) val_m[i] = 1'b0;
        latch_m = '0;
        for (sw = 0; sw < lim && !settled; sw++) begin
          chg = 1'b0;
          for (int g = 0; g < total_m; g++) begin
            id = order_m[g];
            a = src_val(pin_m[id*2], it.circuit_inputs);
            b = (kind_m[id] != GT_NOT) ? src_val(pin_m[id*2+1], it.circuit_inputs) : 1'b0;
            nv = gate_fn(kind_m[id], a, b);
            if (val_m[id] != nv) begin
              val_m[id] = nv;
              chg = 1'b1;
            end
          end
          for (int k = 0; k < NOUT; k++) begin
            nv = src_val(osrc_m[k], it.circuit_inputs);
            if (latch_m[k] != nv) begin
              latch_m[k] = nv;
              chg = 1'b1;
            end
          end
          if (!chg) settled = 1'b1;
        end
        has = 1'b1;
        res = '{hex: latch_m, conv: settled};
      end
    endcase
  endtask

  task automatic report(string what, logic [3:0] got, logic [3:0] want);
    n_err++;
    $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // transfer monitor and result checker
  always @(posedge clk_i) begin
    item_t    it;
    bit       has;
    outcome_t res;
    outcome_t want;
    if (rst_ni && in_if.valid && in_if.ready) begin
      it = '{in_if.kind, in_if.gate_id, in_if.gate_type, in_if.src_kind, in_if.from_id,
             in_if.to_type, in_if.to_id, in_if.to_pin, in_if.circuit_inputs, 1'b0, 4'd0, 1'b0};
      netlist_step(it, has, res);
      if (has) begin
        if (cur_typed) res = '{hex: cur_hex, conv: cur_conv};
        outcome_q.push_back(res);
        n_eval++;
        if (!res.conv) n_osc++;
      end
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (outcome_q.size() == 0) begin
        report("unexpected transfer, hex_value", out_if.hex_value, 4'd0);
      end else begin
        want = outcome_q.pop_front();
        if (out_if.hex_value !== want.hex) report("hex_value", out_if.hex_value, want.hex);
        if (out_if.converged !== want.conv) report("converged", out_if.converged, want.conv);
      end
    end
  end

  // receiver stalls
  initial begin
    int mode;
    int left;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = (mode == 2) ? $urandom_range(1, 30) : $urandom_range(1, 60);
      end
      left--;
      case (mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= 1'b0;
      endcase
    end
  end

  function automatic item_t rnd_item(logic [1:0] k);
    item_t it;
    it.kind = k;
    it.gate_id = 8'($urandom_range(0, 255));
    it.gate_type = 3'($urandom_range(0, 7));
    it.src_kind = 2'($urandom_range(0, 3));
    it.from_id = 8'($urandom_range(0, 255));
    it.to_type = 1'($urandom_range(0, 1));
    it.to_id = 8'($urandom_range(0, 255));
    it.to_pin = 8'($urandom_range(0, 255));
    it.circuit_inputs = 4'($urandom_range(0, 15));
    it.typed = 1'b0;
    it.hex = '0;
    it.conv = 1'b0;
    return it;
  endfunction

  function automatic item_t wire_it(logic [1:0] ft, logic [7:0] fid, logic tt,
                                    logic [7:0] tid, logic [7:0] tp);
    item_t it;
    it = rnd_item(KIND_WIRE);
    it.src_kind = ft;
    it.from_id = fid;
    it.to_type = tt;
    it.to_id = tid;
    it.to_pin = tp;
    return it;
  endfunction

  task automatic gen_netlist();
    int         n;
    int         r;
    logic [7:0] ids [];
    item_t      it;
    logic [7:0] src;
    logic [1:0] ft;
    if ($urandom_range(0, 24) == 0 && n_big < 3) begin
      n = NGATE + $urandom_range(0, 3);
      n_big++;
    end else begin
      n = $urandom_range(1, 8);
    end
    ids = new[n];
    foreach (ids[i]) ids[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 15));
    if ($urandom_range(0, 7) != 0) stim_q.push_back(rnd_item(KIND_CLEAR));
    foreach (ids[i]) begin
      it = rnd_item(KIND_GATE);
      it.gate_id = ids[i];
      it.gate_type = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      stim_q.push_back(it);
    end
    foreach (ids[i]) begin
      for (int p = 0; p < 2; p++) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          ft = SRC_INPUT;
          src = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 3));
        end else if (r < 8) begin
          ft = SRC_GATE;
          src = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : ids[$urandom_range(0, n-1)];
        end else begin
          ft = 2'($urandom_range(2, 3));
          src = 8'($urandom_range(0, 255));
        end
        if (r != 9) stim_q.push_back(wire_it(ft, src, TO_PIN, ids[i], 8'(p)));
      end
    end
    for (int k = 0; k < NOUT; k++) begin
      if ($urandom_range(0, 5) != 0) begin
        if ($urandom_range(0, 2) == 0)
          stim_q.push_back(wire_it(SRC_INPUT, 8'($urandom_range(0, 4)), 1'b1, 8'd0, 8'(k)));
        else
          stim_q.push_back(wire_it(SRC_GATE, ids[$urandom_range(0, n-1)], 1'b1, 8'd0, 8'(k)));
      end
    end
    if ($urandom_range(0, 3) == 0) stim_q.push_back(rnd_item(KIND_WIRE));
    r = $urandom_range(1, 3);
    for (int e = 0; e < r; e++) stim_q.push_back(rnd_item(KIND_EVAL));
  endtask

  task automatic send(item_t it);
    in_if.valid <= 1'b1;
    in_if.kind <= it.kind;
    in_if.gate_id <= it.gate_id;
    in_if.gate_type <= it.gate_type;
    in_if.src_kind <= it.src_kind;
    in_if.from_id <= it.from_id;
    in_if.to_type <= it.to_type;
    in_if.to_id <= it.to_id;
    in_if.to_pin <= it.to_pin;
    in_if.circuit_inputs <= it.circuit_inputs;
    cur_typed <= it.typed;
    cur_hex <= it.hex;
    cur_conv <= it.conv;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    in_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  initial begin
    int burst;
    int sent;
    n_err = 0;
    n_eval = 0;
    n_osc = 0;
    n_big = 0;
    total_m = 0;
    latch_m = '0;
    foreach (val_m[i]) val_m[i] = 1'b0;
    foreach (pin_m[i]) pin_m[i] = '0;
    foreach (osrc_m[i]) osrc_m[i] = '0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_CLEAR;
    in_if.gate_id = '0;
    in_if.gate_type = GT_AND;
    in_if.src_kind = SRC_INPUT;
    in_if.from_id = '0;
    in_if.to_type = TO_PIN;
    in_if.to_id = '0;
    in_if.to_pin = '0;
    in_if.circuit_inputs = '0;
    cur_typed = 1'b0;
    cur_hex = '0;
    cur_conv = 1'b0;
    rst_ni = 1'b0;

    dir_tab = '{
      '{KIND_EVAL,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'hf, 1, 4'h0, 1},
      '{KIND_GATE,  8'd5,   GT_NOT,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_GATE,  8'd5,   1'b0, 8'd5,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_GATE,  8'd5,   1'b1, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_EVAL,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 1, 4'h1, 0},
      '{KIND_CLEAR, 8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_EVAL,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'hf, 1, 4'h0, 1},
      '{KIND_GATE,  8'd255, GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_GATE,  8'd1,   GT_XNOR, SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_GATE,  8'd2,   3'd7,    SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd255, 8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_INPUT, 8'd1,   1'b0, 8'd255, 8'd1,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_GATE,  8'd255, 1'b0, 8'd1,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  2'd3,      8'd255, 1'b0, 8'd1,   8'd1,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_INPUT, 8'd200, 1'b0, 8'd2,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_GATE,  8'd1,   1'b1, 8'd0,   8'd1,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_INPUT, 8'd3,   1'b1, 8'd0,   8'd3,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_GATE,  8'd99,  1'b1, 8'd0,   8'd2,   4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd1,   8'd255, 4'h0, 0, 4'h0, 0},
      '{KIND_WIRE,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b1, 8'd1,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_EVAL,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'hf, 0, 4'h0, 0},
      '{KIND_GATE,  8'd255, GT_NAND, SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h0, 0, 4'h0, 0},
      '{KIND_EVAL,  8'd0,   GT_AND,  SRC_INPUT, 8'd0,   1'b0, 8'd0,   8'd0,   4'h3, 0, 4'h0, 0}
    };

    while (stim_q.size() < 1250) gen_netlist();

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send(dir_tab[i]);
    idle_gap(1);
    while (outcome_q.size() != 0) @(negedge clk_i);

    sent = 0;
    while (sent < stim_q.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < stim_q.size()) begin
        send(stim_q[sent]);
        sent++;
        burst--;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    idle_gap(1);
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);

    $display("Ran %0d directed and %0d random transfers, %0d evaluations,",
             $size(dir_tab), stim_q.size(), n_eval);
    $display("%0d of them hit the sweep limit, %0d full netlists", n_osc, n_big);
    if (n_err == 0 && outcome_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
